FILE: rtl/salru_pkg.sv
// Shared types and constants for the set-associative cache model.
// Used by salru_ctrl, salru_dp and set_assoc_cache_lru_model.
`timescale 1ns / 1ps

package salru_pkg;

  localparam int Ways       = 8;
  localparam int MaxSetBits = 10;
  localparam int AgeBits    = 32;
  localparam int TagBits    = 32;
  localparam int NumSets    = 1 << MaxSetBits;
  localparam int WayBits    = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int CntBits    = 32;

  localparam logic [1:0] CfgSetBits    = 2'd0;
  localparam logic [1:0] CfgWaysInUse  = 2'd1;
  localparam logic [1:0] CfgBlockBits  = 2'd2;

  localparam logic [1:0] OpModify      = 2'd2;

  localparam logic [1:0] OutcomeHit    = 2'd0;
  localparam logic [1:0] OutcomeFill   = 2'd1;
  localparam logic [1:0] OutcomeEvict  = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [TagBits-1:0] tag;
    logic [AgeBits-1:0] age;
  } line_t;

  typedef line_t [Ways-1:0] row_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

FILE: rtl/salru_ctrl.sv
// Controller state machine: reset clearing pass, request capture, set update.
// Depends on salru_pkg.
`timescale 1ns / 1ps

module salru_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output salru_pkg::dp_cmd_t    cmd_o,
  input  salru_pkg::dp_status_t status_i
);
  import salru_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    out_valid_d   = out_valid_q && out_stall_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        if (slot_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/salru_dp.sv
// Datapath: configuration, set memory, hit/fill/evict decision, counters.
// Depends on salru_pkg.
`timescale 1ns / 1ps

module salru_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [5:0]                cfg_data_i,
  input  logic [1:0]                operation_i,
  input  logic [63:0]               address_i,
  input  salru_pkg::dp_cmd_t        cmd_i,
  output salru_pkg::dp_status_t     status_o,
  output logic [1:0]                outcome_o,
  output logic [2:0]                way_used_o,
  output logic [31:0]               hits_total_o,
  output logic [31:0]               misses_total_o,
  output logic [31:0]               evictions_total_o
);
  import salru_pkg::*;

  logic [3:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] block_bits_q;

  row_t mem [NumSets];
  row_t rd_q;

  logic [MaxSetBits-1:0] clr_q;
  logic [MaxSetBits-1:0] set_q;
  logic [TagBits-1:0]    tag_q;
  logic                  modify_q;

  logic [CntBits-1:0] hits_q, misses_q, evicts_q;
  logic [CntBits-1:0] hits_d, misses_d, evicts_d;
  logic [1:0]         outcome_q;
  logic [2:0]         way_q;

  logic [3:0]            s_eff;
  logic [3:0]            nways;
  logic [63:0]           shifted;
  logic [MaxSetBits:0]   set_mask;
  logic [MaxSetBits-1:0] set_c;
  logic [6:0]            tag_sh;
  logic [63:0]           tag_full;
  logic [TagBits-1:0]    tag_c;

  always_comb begin
    s_eff    = (set_bits_q > 4'(MaxSetBits)) ? 4'(MaxSetBits) : set_bits_q;
    nways    = (ways_q == 4'd0) ? 4'd1 : ((ways_q > 4'(Ways)) ? 4'(Ways) : ways_q);
    shifted  = address_i >> block_bits_q;
    set_mask = ((MaxSetBits+1)'(1) << s_eff) - (MaxSetBits+1)'(1);
    set_c    = shifted[MaxSetBits-1:0] & set_mask[MaxSetBits-1:0];
    tag_sh   = 7'(s_eff) + 7'(block_bits_q);
    tag_full = address_i >> tag_sh[5:0];
    tag_c    = tag_sh[6] ? '0 : tag_full[TagBits-1:0];
  end

  logic               hit;
  logic [WayBits-1:0] hit_way;
  logic               have_inv;
  logic [WayBits-1:0] inv_way;
  logic               have_lru;
  logic [WayBits-1:0] lru_way;
  logic [AgeBits-1:0] lru_age;
  logic [WayBits-1:0] touched;
  row_t               new_row;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    have_inv = 1'b0;
    inv_way  = '0;
    have_lru = 1'b0;
    lru_way  = '0;
    lru_age  = '0;
    for (int w = 0; w < Ways; w++) begin
      if (4'(w) < nways) begin
        if (!rd_q[w].valid) begin
          have_inv = 1'b1;
          inv_way  = WayBits'(w);
        end else begin
          if (!have_lru || rd_q[w].age <= lru_age) begin
            have_lru = 1'b1;
            lru_age  = rd_q[w].age;
            lru_way  = WayBits'(w);
          end
          if (!hit && rd_q[w].tag == tag_q) begin
            hit     = 1'b1;
            hit_way = WayBits'(w);
          end
        end
      end
    end
    priority if (hit) touched = hit_way;
    else if (have_inv) touched = inv_way;
    else touched = lru_way;

    new_row = rd_q;
    for (int w = 0; w < Ways; w++) begin
      if (4'(w) < nways) new_row[w].age = rd_q[w].age >> 1;
    end
    new_row[touched].age[AgeBits-1] = 1'b1;
    if (!hit) begin
      new_row[touched].valid = 1'b1;
      new_row[touched].tag   = tag_q;
    end
  end

  function automatic logic [CntBits-1:0] sat_add(logic [CntBits-1:0] v, logic [1:0] n);
    logic [CntBits:0] sum;
    sum = {1'b0, v} + (CntBits+1)'(n);
    return sum[CntBits] ? '1 : sum[CntBits-1:0];
  endfunction

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (hit) begin
      hits_d = sat_add(hits_q, modify_q ? 2'd2 : 2'd1);
    end else begin
      misses_d = sat_add(misses_q, 2'd1);
      if (!have_inv) evicts_d = sat_add(evicts_q, 2'd1);
      if (modify_q) hits_d = sat_add(hits_q, 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 4'd10;
      ways_q       <= 4'd2;
      block_bits_q <= 6'd8;
      clr_q        <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgSetBits:   set_bits_q   <= cfg_data_i[3:0];
          CfgWaysInUse: ways_q       <= cfg_data_i[3:0];
          CfgBlockBits: block_bits_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.update) begin
        hits_q   <= hits_d;
        misses_q <= misses_d;
        evicts_q <= evicts_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.update) begin
      mem[set_q] <= new_row;
    end
    if (cmd_i.capture) begin
      rd_q     <= mem[set_c];
      set_q    <= set_c;
      tag_q    <= tag_c;
      modify_q <= (operation_i == OpModify);
    end
    if (cmd_i.update) begin
      outcome_q <= hit ? OutcomeHit : (have_inv ? OutcomeFill : OutcomeEvict);
      way_q     <= 3'(touched);
    end
  end

  assign status_o.clear_last = (clr_q == '1);
  assign outcome_o           = outcome_q;
  assign way_used_o          = way_q;
  assign hits_total_o        = hits_q;
  assign misses_total_o      = misses_q;
  assign evictions_total_o   = evicts_q;

endmodule

FILE: rtl/set_assoc_cache_lru_model.sv
// Top level of the set-associative cache model: controller plus datapath.
// Depends on salru_pkg, salru_ctrl and salru_dp.
`timescale 1ns / 1ps

// After reset the block runs a clearing pass over all 1024 sets, one set per
// cycle, and accepts no request until it ends; configuration writes are
// taken throughout. For each request the set row is read from the set
// memory in the accept cycle, and hit/fill/evict is decided and the row
// written back afterwards in the look state. A result waits in an output
// register while the next request is accepted; the update waits only if
// that register is still full and stalled.
module set_assoc_cache_lru_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [2:0]  way_used_o,
  output logic [31:0] hits_total_o,
  output logic [31:0] misses_total_o,
  output logic [31:0] evictions_total_o
);
  import salru_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  salru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  salru_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .outcome_o         (outcome_o),
    .way_used_o        (way_used_o),
    .hits_total_o      (hits_total_o),
    .misses_total_o    (misses_total_o),
    .evictions_total_o (evictions_total_o)
  );

endmodule

FILE: tb/tb_set_assoc_cache_lru_model.sv
// Self-checking bench for set_assoc_cache_lru_model: random cache accesses against a
// local LRU-aging cache predictor, with random stalls. Depends on salru_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_model;
  import salru_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr;
  } access_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [2:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } cache_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [5:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [63:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  outcome_o;
  logic [2:0]  way_used_o;
  logic [31:0] hits_total_o, misses_total_o, evictions_total_o;

  set_assoc_cache_lru_model u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic        pv_valid [NumSets*Ways];
  logic [31:0] pv_tag   [NumSets*Ways];
  logic [31:0] pv_age   [NumSets*Ways];
  logic [31:0] p_hits, p_miss, p_evict;
  logic [3:0]  p_sbits, p_ways;
  logic [5:0]  p_bbits;

  access_t    pending_q[$];
  cache_res_t expected_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  bit hold_req = 0;
  bit in_taken = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v, int n);
    return ({1'b0, v} + n > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : v + n;
  endfunction

  function automatic cache_res_t predict_access(access_t a);
    int unsigned s, nw, b, set, base, lru_way, wsel;
    int inv;
    logic [31:0] tag, lru_age;
    bit have_lru, hit;
    cache_res_t r;
    s = (p_sbits > MaxSetBits) ? MaxSetBits : p_sbits;
    nw = (p_ways < 1) ? 1 : ((p_ways > Ways) ? Ways : p_ways);
    b = p_bbits;
    set = (a.addr >> b) & ((64'd1 << s) - 1);
    tag = (s + b < 64) ? 32'(a.addr >> (s + b)) : 32'd0;
    base = set * Ways;
    inv = -1; have_lru = 0; hit = 0; lru_way = 0; lru_age = 0; wsel = 0;
    for (int w = 0; w < nw && !hit; w++) begin
      if (!pv_valid[base+w]) begin
        inv = w;
      end else begin
        if (!have_lru || pv_age[base+w] <= lru_age) begin
          lru_age = pv_age[base+w]; lru_way = w; have_lru = 1;
        end
        if (pv_tag[base+w] == tag) begin
          hit = 1; wsel = w;
        end
      end
    end
    if (hit) begin
      p_hits = sat_inc(p_hits, (a.op == OpModify) ? 2 : 1);
      r.outcome = OutcomeHit;
    end else begin
      p_miss = sat_inc(p_miss, 1);
      if (inv < 0) begin
        p_evict = sat_inc(p_evict, 1);
        wsel = lru_way; r.outcome = OutcomeEvict;
      end else begin
        wsel = inv; r.outcome = OutcomeFill;
      end
      pv_valid[base+wsel] = 1;
      pv_tag[base+wsel] = tag;
      if (a.op == OpModify) p_hits = sat_inc(p_hits, 1);
    end
    for (int w = 0; w < nw; w++) pv_age[base+w] = pv_age[base+w] >> 1;
    pv_age[base+wsel][AgeBits-1] = 1'b1;
    r.way = 3'(wsel); r.hits = p_hits; r.misses = p_miss; r.evicts = p_evict;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk_i) begin
    bit took;
    took = in_taken;
    in_taken = 0;
    if (rst_ni) begin
      if (took) begin
        void'(pending_q.pop_front());
      end
      if (took || !in_valid_i) begin
        if (pending_q.size() > 0 && !hold_req && $urandom_range(99) >= send_idle) begin
          in_valid_i  <= 1'b1;
          operation_i <= pending_q[0].op;
          address_i   <= pending_q[0].addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall);
      end
    end
  end

  // predict at accept, check at result
  always @(posedge clk_i) begin
    cache_res_t e;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_q.push_back(predict_access('{operation_i, address_i}));
      in_taken = 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = expected_q.pop_front();
        if (outcome_o !== e.outcome) report_mismatch("outcome", outcome_o, e.outcome);
        if (way_used_o !== e.way) report_mismatch("way_used", way_used_o, e.way);
        if (hits_total_o !== e.hits) report_mismatch("hits_total", hits_total_o, e.hits);
        if (misses_total_o !== e.misses)
          report_mismatch("misses_total", misses_total_o, e.misses);
        if (evictions_total_o !== e.evicts)
          report_mismatch("evictions_total", evictions_total_o, e.evicts);
      end
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSetBits:   p_sbits = cfg_data_i[3:0];
        CfgWaysInUse: p_ways  = cfg_data_i[3:0];
        CfgBlockBits: p_bbits = cfg_data_i;
        default: ;
      endcase
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(logic [5:0] s, logic [5:0] w, logic [5:0] b);
    write_reg(CfgSetBits, s);
    write_reg(CfgWaysInUse, w);
    write_reg(CfgBlockBits, b);
    write_reg(2'd3, 6'h3F);
  endtask

  function automatic logic [63:0] rand_addr();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(3))
      0: a = a & 64'h0000_0000_0000_7FFF;
      1: a = a & 64'hFFFF_0000_0000_3FFF;
      2: a = {a[63:16], 16'h0} | $urandom_range(15);
      default: ;
    endcase
    return a;
  endfunction

  task automatic push_random(int n, int tag_pool);
    logic [63:0] pool [8];
    access_t a;
    foreach (pool[i]) pool[i] = rand_addr();
    for (int i = 0; i < n; i++) begin
      a.op = $urandom_range(3);
      if ($urandom_range(9) < 7) a.addr = pool[$urandom_range(tag_pool - 1)] ^ $urandom_range(1);
      else a.addr = rand_addr();
      pending_q.push_back(a);
    end
  endtask

  initial begin
    for (int i = 0; i < NumSets*Ways; i++) begin
      pv_valid[i] = 0; pv_tag[i] = 0; pv_age[i] = 0;
    end
    p_hits = 0; p_miss = 0; p_evict = 0;
    p_sbits = 4'd10; p_ways = 4'd2; p_bbits = 6'd8;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and every op with a single set and a single way
    set_geometry(6'd0, 6'd0, 6'd1);
    pending_q.push_back('{2'd0, 64'h0});
    pending_q.push_back('{2'd1, 64'h0});
    pending_q.push_back('{2'd2, 64'h0});
    pending_q.push_back('{2'd3, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_q.push_back('{2'd2, 64'h8000_0000_0000_0000});
    pending_q.push_back('{2'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    wait_drained();
    set_geometry(6'd15, 6'd15, 6'd63);
    for (int i = 0; i < 10; i++)
      pending_q.push_back('{i[1:0], {$urandom, $urandom}});
    wait_drained();
    set_geometry(6'd10, 6'd8, 6'd54);
    pending_q.push_back('{2'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_q.push_back('{2'd2, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_q.push_back('{2'd1, 64'h0040_0000_0000_0000});
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 80; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 80; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      case (ph % 6)
        0: set_geometry(6'd1, 6'd1, 6'd1);
        1: set_geometry(6'd2, 6'd4, 6'd4);
        2: set_geometry(6'd1, 6'd8, 6'd8);
        3: set_geometry(6'd3, 6'd3, 6'd30);
        4: set_geometry(6'd12, 6'd9, 6'd60);
        default: set_geometry(6'(1 + $urandom_range(9)), 6'($urandom_range(15)),
                              6'($urandom_range(63)));
      endcase
      if (ph == 4) hold_cycles = 300;
      push_random(125, 2 + $urandom_range(6));
      if (ph == 6) begin
        while (pending_q.size() > 60) @(posedge clk_i);
        hold_req = 1;
        while (expected_q.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_req = 0;
      end
      wait_drained();
    end
    send_idle = 0; recv_stall = 0;
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[set_assoc_cache_lru_model] OK");
    end else begin
      $display("[set_assoc_cache_lru_model] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[set_assoc_cache_lru_model] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/salru_pkg.sv
rtl/salru_ctrl.sv
rtl/salru_dp.sv
rtl/set_assoc_cache_lru_model.sv
tb/tb_set_assoc_cache_lru_model.sv
